// File: sv/elevator_car_controller_unit_assert.svh
// Assertion macros for the file that checks the elevator car controller.
`ifndef ELEVATOR_CAR_CONTROLLER_UNIT_ASSERT_SVH
`define ELEVATOR_CAR_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define ECC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ecc_pkg.sv
// Types, codes and constants of the elevator car controller.
package ecc_pkg;

	localparam int FLOOR_W   = 5;
	localparam int HEIGHT_W  = 24;
	localparam int SPEED_W   = 16;
	localparam int TIMER_W   = 20;
	localparam int POS_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [FLOOR_W-1:0] MIN_FLOORS = 5'd5;
	localparam logic [FLOOR_W-1:0] MAX_FLOORS = 5'd20;

	typedef logic [FLOOR_W-1:0] floor_t;

	// Request types
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_CALL  = 2'd1;
	localparam logic [1:0] REQ_PRESS = 2'd2;

	// Car modes
	localparam logic [1:0] MODE_STOP  = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_OPEN  = 2'd2;
	localparam logic [1:0] MODE_CLOSE = 2'd3;

	// Door events
	localparam logic [1:0] DOOR_NONE   = 2'd0;
	localparam logic [1:0] DOOR_OPENED = 2'd1;
	localparam logic [1:0] DOOR_CLOSED = 2'd2;

	// Pending command kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_CALL  = 2'd1;
	localparam logic [1:0] KIND_PRESS = 2'd2;

	// Travel directions
	localparam logic [1:0] DIR_ZERO = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS   = 2'd3;

	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 24'd768000;
	localparam logic [SPEED_W-1:0]  SPEED_RESET  = 16'd256;
	localparam logic [TIMER_W-1:0]  DOOR_RESET   = 20'd3000;

	typedef struct packed {
		floor_t                floor_count;
		logic [HEIGHT_W-1:0]   floor_height;
		logic [SPEED_W-1:0]    speed_per_tick;
		logic [TIMER_W-1:0]    door_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]              mode;
		floor_t                  floor_num;
		floor_t                  target;
		floor_t                  pend_floor;
		logic [1:0]              pend_kind;
		logic [1:0]              dir;
		logic signed [POS_W-1:0] pos;
		logic [TIMER_W-1:0]      timer;
	} car_state_t;

	typedef struct packed {
		floor_t     current_floor;
		logic [1:0] car_mode;
		logic [1:0] door_event;
		logic       floor_changed;
		logic       accepted;
	} result_t;

endpackage

// File: sv/ecc_if.sv
// Request and result channel interfaces of the elevator car controller.
interface ecc_req_if;
	import ecc_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	floor_t     floor_request;

	modport source(output valid, req_type, floor_request, input ready);
	modport sink(input valid, req_type, floor_request, output ready);
endinterface

interface ecc_res_if;
	import ecc_pkg::*;

	logic       valid;
	logic       ready;
	floor_t     current_floor;
	logic [1:0] car_mode;
	logic [1:0] door_event;
	logic       floor_changed;
	logic       accepted;

	modport source(output valid, current_floor, car_mode, door_event, floor_changed, accepted,
		input ready);
	modport sink(input valid, current_floor, car_mode, door_event, floor_changed, accepted,
		output ready);
endinterface

// File: sv/ecc_step.sv
// Next-state and result logic for one item applied to the car state.
module ecc_step (
	input  ecc_pkg::car_state_t st,
	input  ecc_pkg::cfg_t       cfg,
	input  logic [1:0]          req_type,
	input  ecc_pkg::floor_t     floor_request,
	output ecc_pkg::car_state_t st_next,
	output ecc_pkg::result_t    result
);
	import ecc_pkg::*;

	localparam int SUM_W = POS_W + 2;

	function automatic logic [1:0] dir_of(input floor_t target, input floor_t here);
		if (target > here) return DIR_UP;
		else if (target < here) return DIR_DOWN;
		else return DIR_ZERO;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] s);
		if (s[SUM_W-1:POS_W-1] == '0 || s[SUM_W-1:POS_W-1] == '1)
			return s[POS_W-1:0];
		else if (s[SUM_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	logic [FLOOR_W+HEIGHT_W-1:0] fh;
	logic signed [SUM_W-1:0]     up_thr;
	logic signed [SUM_W-1:0]     dn_thr;
	logic signed [SUM_W-1:0]     pos_ext;
	logic signed [SUM_W-1:0]     spd_ext;
	logic signed [POS_W-1:0]     pos_up;
	logic signed [POS_W-1:0]     pos_dn;
	logic [TIMER_W-1:0]          tmr_inc;
	logic                        req_ok;

	// Upward crossing lies at floor*height, downward at (floor-2)*height,
	// both measured from floor one at position zero.
	assign fh      = (FLOOR_W+HEIGHT_W)'(st.floor_num) * (FLOOR_W+HEIGHT_W)'(cfg.floor_height);
	assign up_thr  = $signed({{(SUM_W-FLOOR_W-HEIGHT_W){1'b0}}, fh});
	assign dn_thr  = up_thr - $signed({{(SUM_W-HEIGHT_W-1){1'b0}}, cfg.floor_height, 1'b0});
	assign pos_ext = SUM_W'(st.pos);
	assign spd_ext = $signed({{(SUM_W-SPEED_W){1'b0}}, cfg.speed_per_tick});
	assign pos_up  = sat_pos(pos_ext + spd_ext);
	assign pos_dn  = sat_pos(pos_ext - spd_ext);
	assign tmr_inc = (st.timer == '1) ? st.timer : st.timer + 1'b1;
	assign req_ok  = (floor_request != '0) && (floor_request <= cfg.floor_count);

	always_comb begin
		st_next              = st;
		result.door_event    = DOOR_NONE;
		result.floor_changed = 1'b0;
		result.accepted      = 1'b0;

		case (req_type)
			REQ_TICK: begin
				if (st_next.pend_kind != KIND_NONE &&
				    (st_next.mode == MODE_STOP || st_next.mode == MODE_RUN)) begin
					st_next.mode = MODE_RUN;
					if (st_next.pend_kind == KIND_PRESS) begin
						st_next.target = st_next.pend_floor;
						st_next.dir    = dir_of(st_next.target, st_next.floor_num);
					end
					st_next.pend_kind = KIND_NONE;
				end

				if (st_next.mode != MODE_STOP) begin
					if (st_next.floor_num == st_next.target) begin
						if (st_next.mode == MODE_RUN) begin
							st_next.mode  = MODE_OPEN;
							st_next.timer = '0;
						end else begin
							// Timer and door phase are untouched by the pending step.
							st_next.timer = tmr_inc;
							if (tmr_inc >= cfg.door_ticks) begin
								st_next.timer = '0;
								if (st_next.mode == MODE_OPEN) begin
									result.door_event = DOOR_OPENED;
									st_next.mode      = MODE_CLOSE;
								end else begin
									result.door_event = DOOR_CLOSED;
									st_next.mode      = MODE_STOP;
									if (st_next.pend_kind == KIND_PRESS) begin
										st_next.target = st_next.pend_floor;
										st_next.dir    = dir_of(st_next.target,
											st_next.floor_num);
										st_next.mode   = MODE_RUN;
									end
									st_next.pend_kind = KIND_NONE;
								end
							end
						end
					end else if (st_next.mode == MODE_RUN) begin
						if (st_next.dir == DIR_UP) begin
							st_next.pos = pos_up;
							if (SUM_W'(pos_up) > up_thr) begin
								st_next.floor_num    = st.floor_num + 1'b1;
								result.floor_changed = 1'b1;
							end
						end else if (st_next.dir == DIR_DOWN) begin
							st_next.pos = pos_dn;
							if (SUM_W'(pos_dn) < dn_thr) begin
								st_next.floor_num    = st.floor_num - 1'b1;
								result.floor_changed = 1'b1;
							end
						end
					end
				end
			end
			REQ_CALL: begin
				if (req_ok && st.mode == MODE_STOP && st.pend_kind == KIND_NONE) begin
					st_next.pend_kind = KIND_CALL;
					st_next.target    = floor_request;
					st_next.dir       = dir_of(floor_request, st.floor_num);
					result.accepted   = 1'b1;
				end
			end
			REQ_PRESS: begin
				if (req_ok) begin
					st_next.pend_kind  = KIND_PRESS;
					st_next.pend_floor = floor_request;
					st_next.dir        = dir_of(st.target, st.floor_num);
					result.accepted    = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result.current_floor = st_next.floor_num;
		result.car_mode      = st_next.mode;
	end

endmodule

// File: sv/elevator_car_controller_unit.sv
// Elevator car controller top level: input stage, car state, configuration and result register.
// Takes one item per clock cycle while the result sink keeps up, and gives exactly one result item for each.
// An accepted item is registered in the input stage; when the result register can advance, the
// car state is updated from it and the result is registered, which raises res.valid. The state
// update is combinational through the floor-height multiply (5 by 24 bits), the saturating
// position add and the floor crossing compare. While the sink stalls, the input register can
// still take one item; once it and the result register are both full, ready falls until the
// sink takes the waiting result.
module elevator_car_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ecc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ecc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	ecc_req_if.sink                             req,
	ecc_res_if.source                           res
);
	import ecc_pkg::*;

	cfg_t       cfg_q;
	car_state_t st_q;
	car_state_t st_next;
	result_t    step_res;
	result_t    res_q;
	logic       res_valid_q;
	logic       s1_valid_q;
	logic [1:0] req_type_s1;
	floor_t     floor_request_s1;
	floor_t     fc_wr;
	logic       advance;

	assign advance   = !res_valid_q || res.ready;
	assign req.ready = !s1_valid_q || advance;

	// Floor count is clamped to the served range as it is written.
	always_comb begin
		fc_wr = cfg_wdata[FLOOR_W-1:0];
		if (fc_wr < MIN_FLOORS) fc_wr = MIN_FLOORS;
		else if (fc_wr > MAX_FLOORS) fc_wr = MAX_FLOORS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_count    <= MAX_FLOORS;
			cfg_q.floor_height   <= HEIGHT_RESET;
			cfg_q.speed_per_tick <= SPEED_RESET;
			cfg_q.door_ticks     <= DOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLOOR_COUNT:  cfg_q.floor_count    <= fc_wr;
				CFG_FLOOR_HEIGHT: cfg_q.floor_height   <= cfg_wdata[HEIGHT_W-1:0];
				CFG_SPEED:        cfg_q.speed_per_tick <= cfg_wdata[SPEED_W-1:0];
				CFG_DOOR_TICKS:   cfg_q.door_ticks     <= cfg_wdata[TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1      <= req.req_type;
			floor_request_s1 <= req.floor_request;
		end
	end

	ecc_step u_step (
		.st            (st_q),
		.cfg           (cfg_q),
		.req_type      (req_type_s1),
		.floor_request (floor_request_s1),
		.st_next       (st_next),
		.result        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode       <= MODE_STOP;
			st_q.floor_num  <= 5'd1;
			st_q.target     <= 5'd1;
			st_q.pend_floor <= 5'd1;
			st_q.pend_kind  <= KIND_NONE;
			st_q.dir        <= DIR_ZERO;
			st_q.pos        <= '0;
			st_q.timer      <= '0;
			res_valid_q     <= 1'b0;
		end else if (advance) begin
			res_valid_q <= s1_valid_q;
			if (s1_valid_q) st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) res_q <= step_res;
	end

	assign res.valid         = res_valid_q;
	assign res.current_floor = res_q.current_floor;
	assign res.car_mode      = res_q.car_mode;
	assign res.door_event    = res_q.door_event;
	assign res.floor_changed = res_q.floor_changed;
	assign res.accepted      = res_q.accepted;

endmodule

// File: sv/ecc_checker.sv
// Port-level checks of the elevator car controller and their binding to the top level.
module ecc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input ecc_pkg::floor_t res_current_floor,
	input logic [1:0]      res_car_mode,
	input logic [1:0]      res_door_event,
	input logic            res_floor_changed,
	input logic            res_accepted
);
	import ecc_pkg::*;

`include "elevator_car_controller_unit_assert.svh"

	`ECC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_current_floor) && $stable(res_car_mode) && $stable(res_door_event) && $stable(res_floor_changed) && $stable(res_accepted), "stalled result item changed")

	`ECC_ASSERT_NOW(a_event_only_tick, res_valid && (res_door_event != DOOR_NONE || res_floor_changed), !res_accepted && !(res_floor_changed && res_door_event != DOOR_NONE), "door or floor event on a request item")

	`ECC_ASSERT_NOW(a_open_mode, res_valid && res_door_event == DOOR_OPENED, res_car_mode == MODE_CLOSE, "doors opened but car not closing")

	`ECC_ASSERT_NOW(a_move_mode, res_valid && (res_floor_changed || res_door_event == DOOR_CLOSED), res_car_mode == MODE_RUN || (res_door_event == DOOR_CLOSED && res_car_mode == MODE_STOP), "floor change or close in wrong mode")

endmodule

bind elevator_car_controller_unit ecc_checker u_ecc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_current_floor (res.current_floor),
	.res_car_mode      (res.car_mode),
	.res_door_event    (res.door_event),
	.res_floor_changed (res.floor_changed),
	.res_accepted      (res.accepted)
);

// File: tb/tb_top.sv
// Self-checking testbench for the elevator car controller: directed trips, random traffic, stalls.
`timescale 1ns / 1ps

module tb_top;
	import ecc_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 10;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_CYCLES     = 300;
	localparam int REPORT_LIMIT    = 10;
	localparam int DRAIN_CYCLES    = 8;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int TRAFFIC_NORMAL   = 0;
	localparam int TRAFFIC_QUIET    = 1;
	localparam int TRAFFIC_PRESSURE = 2;

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ecc_req_if req_ch();
	ecc_res_if res_ch();

	elevator_car_controller_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch)
	);

	cfg_t       car_cfg;
	car_state_t car;
	result_t    car_results_due[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int hold_request   = 0;
	int hold_seen      = 0;
	int stall_left     = 0;
	bit sender_gaps    = 1'b1;
	bit stalls_on      = 1'b1;

	always #HALF_PERIOD clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void aim_car();
		if (car.target > car.floor_num) begin
			car.dir = DIR_UP;
		end else if (car.target < car.floor_num) begin
			car.dir = DIR_DOWN;
		end else begin
			car.dir = DIR_ZERO;
		end
	endfunction

	// Moves the car model by one item and returns the result it gives.
	function automatic result_t advance_car(input logic [1:0] kind, input floor_t fl);
		result_t r;
		longint  p;
		longint  h;
		longint  f;
		logic    fl_ok;
		r = '0;
		fl_ok = (fl >= 5'd1) && (fl <= car_cfg.floor_count);
		case (kind)
			REQ_TICK: begin
				if (car.pend_kind != KIND_NONE && (car.mode == MODE_STOP || car.mode == MODE_RUN)) begin
					car.mode = MODE_RUN;
					if (car.pend_kind == KIND_PRESS) begin
						car.target = car.pend_floor;
						aim_car();
					end
					car.pend_kind = KIND_NONE;
				end
				if (car.mode == MODE_STOP) begin
					// Nothing moves while the car stands.
				end else if (car.floor_num == car.target) begin
					if (car.mode == MODE_RUN) begin
						car.mode = MODE_OPEN;
						car.timer = '0;
					end else begin
						if (car.timer != '1) begin
							car.timer = car.timer + 1'b1;
						end
						if (car.timer >= car_cfg.door_ticks) begin
							car.timer = '0;
							if (car.mode == MODE_OPEN) begin
								r.door_event = DOOR_OPENED;
								car.mode = MODE_CLOSE;
							end else begin
								r.door_event = DOOR_CLOSED;
								car.mode = MODE_STOP;
								// A press that came in during the door cycle starts the next run.
								if (car.pend_kind == KIND_PRESS) begin
									car.target = car.pend_floor;
									aim_car();
									car.mode = MODE_RUN;
								end
								car.pend_kind = KIND_NONE;
							end
						end
					end
				end else if (car.mode == MODE_RUN) begin
					h = longint'(car_cfg.floor_height);
					f = longint'(car.floor_num);
					p = longint'(car.pos);
					if (car.dir == DIR_UP) begin
						p = p + longint'(car_cfg.speed_per_tick);
					end else if (car.dir == DIR_DOWN) begin
						p = p - longint'(car_cfg.speed_per_tick);
					end
					if (p > POS_MAX) begin
						p = POS_MAX;
					end
					if (p < POS_MIN) begin
						p = POS_MIN;
					end
					car.pos = p[POS_W-1:0];
					if (car.dir == DIR_UP && p > f * h) begin
						car.floor_num = car.floor_num + 1'b1;
						r.floor_changed = 1'b1;
					end else if (car.dir == DIR_DOWN && p < (f - 2) * h) begin
						car.floor_num = car.floor_num - 1'b1;
						r.floor_changed = 1'b1;
					end
				end
			end
			REQ_CALL: begin
				if (fl_ok && car.mode == MODE_STOP && car.pend_kind == KIND_NONE) begin
					car.pend_kind = KIND_CALL;
					car.target = fl;
					aim_car();
					r.accepted = 1'b1;
				end
			end
			REQ_PRESS: begin
				if (fl_ok) begin
					car.pend_kind = KIND_PRESS;
					car.pend_floor = fl;
					aim_car();
					r.accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.current_floor = car.floor_num;
		r.car_mode = car.mode;
		return r;
	endfunction

	function automatic cfg_t make_cfg(input int fc, input int h, input int s, input int d);
		cfg_t c;
		c.floor_count = floor_t'(fc);
		c.floor_height = HEIGHT_W'(h);
		c.speed_per_tick = SPEED_W'(s);
		c.door_ticks = TIMER_W'(d);
		return c;
	endfunction

	task automatic send_item(input logic [1:0] kind, input floor_t fl);
		int gap;
		gap = (sender_gaps && $urandom_range(0, 99) < 45) ? gap_len() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.floor_request <= fl;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		car_results_due.push_back(advance_car(kind, fl));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (car_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Writes all four registers, with junk above each field narrower than the data word, then mirrors them in the model.
	task automatic apply_setup(input cfg_t raw);
		logic [CFG_DATA_W-1:0] w;
		floor_t                fc;
		wait_drained();
		w = CFG_DATA_W'($urandom());
		w[FLOOR_W-1:0] = raw.floor_count;
		write_reg(CFG_FLOOR_COUNT, w);
		write_reg(CFG_FLOOR_HEIGHT, raw.floor_height);
		w = CFG_DATA_W'($urandom());
		w[SPEED_W-1:0] = raw.speed_per_tick;
		write_reg(CFG_SPEED, w);
		w = CFG_DATA_W'($urandom());
		w[TIMER_W-1:0] = raw.door_ticks;
		write_reg(CFG_DOOR_TICKS, w);
		cfg_we <= 1'b0;
		fc = raw.floor_count;
		if (fc < MIN_FLOORS) begin
			fc = MIN_FLOORS;
		end
		if (fc > MAX_FLOORS) begin
			fc = MAX_FLOORS;
		end
		car_cfg = raw;
		car_cfg.floor_count = fc;
	endtask

	// Mostly ticks with valid calls and presses, plus some rejected and ignored items.
	task automatic run_traffic(input cfg_t setup, input int n, input int mode);
		int         taken;
		int         pick;
		logic [1:0] kind;
		floor_t     fl;
		apply_setup(setup);
		sender_gaps = (mode == TRAFFIC_NORMAL);
		stalls_on = (mode != TRAFFIC_QUIET);
		if (mode == TRAFFIC_PRESSURE) begin
			hold_request <= hold_request + 1;
		end
		taken = 0;
		while (taken < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				kind = REQ_TICK;
				fl = floor_t'($urandom_range(0, 31));
			end else if (pick < 91) begin
				kind = (pick < 84) ? REQ_CALL : REQ_PRESS;
				fl = floor_t'($urandom_range(1, car_cfg.floor_count));
			end else if (pick < 96) begin
				kind = $urandom_range(0, 1) ? REQ_CALL : REQ_PRESS;
				fl = $urandom_range(0, 1) ? 5'd0
					: floor_t'($urandom_range(car_cfg.floor_count + 1, 31));
			end else begin
				kind = REQ_UNUSED;
				fl = floor_t'($urandom_range(0, 31));
			end
			send_item(kind, fl);
			taken++;
		end
		sender_gaps = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_reset_values();
		send_item(REQ_PRESS, 5'd0);
		send_item(REQ_CALL, 5'd21);
		send_item(REQ_CALL, 5'd20);
		// The press overrides the call; its floor is the current one, so the doors start.
		send_item(REQ_PRESS, 5'd1);
		repeat (2) send_item(REQ_TICK, 5'd0);
	endtask

	task automatic test_directed_trip();
		apply_setup(make_cfg(3, 4, 5, 1));
		send_item(REQ_TICK, 5'd31);
		send_item(REQ_CALL, 5'd3);
		send_item(REQ_PRESS, 5'd5);
		send_item(REQ_PRESS, 5'd6);
		// Climb four floors, open, then close and stop.
		repeat (8) send_item(REQ_TICK, 5'd0);
		send_item(REQ_CALL, 5'd0);
		send_item(REQ_UNUSED, 5'd31);
		send_item(REQ_CALL, 5'd1);
		send_item(REQ_CALL, 5'd2);
		repeat (2) send_item(REQ_TICK, 5'd0);
	endtask

	task automatic test_zero_rates();
		run_traffic(make_cfg(9, 300, 0, 5), 60, TRAFFIC_NORMAL);
		run_traffic(make_cfg(9, 300, 120, 0), 60, TRAFFIC_NORMAL);
	endtask

	task automatic test_backpressure();
		run_traffic(make_cfg(7, 400, 100, 2), 200, TRAFFIC_PRESSURE);
	endtask

	task automatic test_random_traffic();
		run_traffic(make_cfg($urandom_range(0, 31), $urandom_range(500, 1000),
			$urandom_range(1, 800), $urandom_range(0, 6)), 250, TRAFFIC_NORMAL);
		run_traffic(make_cfg(12, 1000, 250, 3), 250, TRAFFIC_QUIET);
		run_traffic(make_cfg(16, 2000, 700, 2), 200, TRAFFIC_NORMAL);
		run_traffic(make_cfg(31, 1, 65535, 1), 150, TRAFFIC_NORMAL);
	endtask

	task automatic test_extreme_settings();
		run_traffic(make_cfg(0, 16777215, 65535, 4), 120, TRAFFIC_NORMAL);
		run_traffic(make_cfg(20, 16777215, 1, 1048575), 40, TRAFFIC_NORMAL);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (hold_seen != hold_request) begin
				hold_seen <= hold_request;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (stalls_on && $urandom_range(0, 99) < 20) begin
					stall_left = gap_len();
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.current_floor = res_ch.current_floor;
			got.car_mode = res_ch.car_mode;
			got.door_event = res_ch.door_event;
			got.floor_changed = res_ch.floor_changed;
			got.accepted = res_ch.accepted;
			if (car_results_due.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT) begin
					$display("%0t: unexpected result: floor %0d mode %0d door %0d changed %0b acc %0b",
						$realtime, got.current_floor, got.car_mode, got.door_event,
						got.floor_changed, got.accepted);
				end
				mismatch_count++;
			end else begin
				want = car_results_due.pop_front();
				if (got.current_floor !== want.current_floor || got.car_mode !== want.car_mode
					|| got.door_event !== want.door_event
					|| got.floor_changed !== want.floor_changed
					|| got.accepted !== want.accepted) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("%0t: expected floor %0d mode %0d door %0d changed %0b acc %0b",
							$realtime, want.current_floor, want.car_mode, want.door_event,
							want.floor_changed, want.accepted);
						$display("%0t:      got floor %0d mode %0d door %0d changed %0b acc %0b",
							$realtime, got.current_floor, got.car_mode, got.door_event,
							got.floor_changed, got.accepted);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
			$display("%0t: timeout, no item moved for %0d cycles", $realtime, WATCHDOG_CYCLES);
			$display("[elevator_car_controller_unit] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FLOOR_COUNT;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_TICK;
		req_ch.floor_request <= '0;

		car_cfg.floor_count = MAX_FLOORS;
		car_cfg.floor_height = HEIGHT_RESET;
		car_cfg.speed_per_tick = SPEED_RESET;
		car_cfg.door_ticks = DOOR_RESET;
		car = '0;
		car.mode = MODE_STOP;
		car.floor_num = 5'd1;
		car.target = 5'd1;
		car.pend_floor = 5'd1;
		car.pend_kind = KIND_NONE;
		car.dir = DIR_ZERO;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_trip();
		test_zero_rates();
		test_backpressure();
		test_random_traffic();
		test_extreme_settings();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && car_results_due.size() == 0) begin
			$display("[elevator_car_controller_unit] OK");
		end else begin
			$display("[elevator_car_controller_unit] ERROR");
		end
		$finish;
	end

endmodule
